// File: sv/sqe_pkg.sv
// Package for the stack/queue engine: field widths, op and status codes,
// and the command type passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sqe_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_DEF   = 64;
  localparam int CMD_Q_DEPTH = 2;

  // Op codes carried on the input tuser.
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_DUMP = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
  localparam logic [OP_W-1:0] OP_POP  = 3'd3;
  localparam logic [OP_W-1:0] OP_SWAP = 3'd4;

  // Status codes reported on the output tuser.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PEEK_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/sqe_front.sv
// Front end of the stack/queue engine: accepts input transactions, drops
// unused op codes and queues the rest as commands for the back end.
// Depends on sqe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sqe_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [sqe_pkg::DATA_W-1:0] s_axis_tdata,  // value
  input  wire logic [sqe_pkg::OP_W-1:0]   s_axis_tuser,  // op
  output logic                           cmd_valid,
  input  wire logic                      cmd_ready,
  output sqe_pkg::cmd_t                  cmd
);
  import sqe_pkg::*;

  localparam int PW = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
  localparam int CW = $clog2(CMD_Q_DEPTH + 1);

  cmd_t          q [CMD_Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          in_fire;
  logic          known_op;
  logic          push_q;
  logic          pop_q;

  assign s_axis_tready = (fill != CW'(CMD_Q_DEPTH));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign known_op      = s_axis_tuser inside {OP_PUSH, OP_DUMP, OP_PEEK, OP_POP, OP_SWAP};
  assign push_q        = in_fire && known_op;
  assign cmd_valid     = (fill != '0);
  assign pop_q         = cmd_valid && cmd_ready;
  assign cmd           = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_q) begin
      q[wr_ptr].op    <= s_axis_tuser;
      q[wr_ptr].value <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_q) begin
        wr_ptr <= (wr_ptr == PW'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_q) begin
        rd_ptr <= (rd_ptr == PW'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_q && !pop_q) begin
        fill <= fill + CW'(1);
      end else if (pop_q && !push_q) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/sqe_back.sv
// Back end of the stack/queue engine: executes queued commands against the
// ring store, walks dumps and holds the output register.
// Depends on sqe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sqe_back #(
  parameter int DEPTH = sqe_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          queue_mode_we,
  input  wire logic                          queue_mode_data,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire sqe_pkg::cmd_t                 cmd,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [sqe_pkg::DATA_W-1:0]         m_axis_tdata,  // data
  output logic [sqe_pkg::STATUS_W:0]         m_axis_tuser,  // data_valid, status
  output logic                               m_axis_tlast   // last
);
  import sqe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEND    = 3'd1;
  localparam logic [2:0] S_SWAP_B  = 3'd2;
  localparam logic [2:0] S_SWAP_WA = 3'd3;
  localparam logic [2:0] S_SWAP_WB = 3'd4;

  // Ring position of an offset from the front entry; offset is below DEPTH.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] offset);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(offset);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  logic [2:0]        state, state_next;
  logic [AW-1:0]     front, front_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     cursor, cursor_next;
  logic              is_peek, is_peek_next;
  logic              queue_mode;
  logic [DATA_W-1:0] tmp;
  logic              tmp_load;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     front_inc;
  logic              out_free;
  logic              load_out;
  logic [DATA_W-1:0] out_data_next;
  logic              out_dv_next;
  logic [STATUS_W-1:0] out_status_next;
  logic              out_last_next;
  logic              send_last;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = slot(front, CW'(1));
  assign send_last = is_peek || (cursor + CW'(1) == count);

  always_comb begin
    state_next      = state;
    front_next      = front;
    count_next      = count;
    cursor_next     = cursor;
    is_peek_next    = is_peek;
    tmp_load        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = front;
    mem_wdata       = rdata;
    mem_re          = 1'b0;
    mem_raddr       = front;
    load_out        = 1'b0;
    out_data_next   = '0;
    out_dv_next     = 1'b0;
    out_status_next = ST_OK;
    out_last_next   = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          case (cmd.op)
            OP_PUSH: begin
              if (count == CW'(DEPTH)) begin
                load_out        = 1'b1;
                out_status_next = ST_PUSH_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = cmd.value;
                if (queue_mode) begin
                  mem_waddr = slot(front, count);
                end else begin
                  mem_waddr  = front_dec;
                  front_next = front_dec;
                end
                count_next = count + CW'(1);
              end
            end
            OP_DUMP: begin
              if (count != '0) begin
                mem_re       = 1'b1;
                cursor_next  = '0;
                is_peek_next = 1'b0;
                state_next   = S_SEND;
              end
            end
            OP_PEEK: begin
              if (count == '0) begin
                load_out        = 1'b1;
                out_status_next = ST_PEEK_EMPTY;
              end else begin
                mem_re       = 1'b1;
                cursor_next  = '0;
                is_peek_next = 1'b1;
                state_next   = S_SEND;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                load_out        = 1'b1;
                out_status_next = ST_POP_EMPTY;
              end else begin
                front_next = front_inc;
                count_next = count - CW'(1);
              end
            end
            OP_SWAP: begin
              if (count < CW'(2)) begin
                load_out        = 1'b1;
                out_status_next = ST_SWAP_SHORT;
              end else begin
                mem_re     = 1'b1;
                state_next = S_SWAP_B;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEND: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_data_next = rdata;
          out_dv_next   = 1'b1;
          out_last_next = send_last;
          if (send_last) begin
            cursor_next = '0;
            state_next  = S_IDLE;
          end else begin
            mem_re      = 1'b1;
            mem_raddr   = slot(front, cursor + CW'(1));
            cursor_next = cursor + CW'(1);
          end
        end
      end
      S_SWAP_B: begin
        tmp_load   = 1'b1;
        mem_re     = 1'b1;
        mem_raddr  = front_inc;
        state_next = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        mem_we     = 1'b1;
        mem_waddr  = front;
        mem_wdata  = rdata;
        state_next = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        mem_we     = 1'b1;
        mem_waddr  = front_inc;
        mem_wdata  = tmp;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Ring store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tmp_load) begin
      tmp <= rdata;
    end
    if (load_out) begin
      m_axis_tdata <= out_data_next;
      m_axis_tuser <= {out_status_next, out_dv_next};
      m_axis_tlast <= out_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      front         <= '0;
      count         <= '0;
      cursor        <= '0;
      is_peek       <= 1'b0;
      queue_mode    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      front   <= front_next;
      count   <= count_next;
      cursor  <= cursor_next;
      is_peek <= is_peek_next;
      if (queue_mode_we) begin
        queue_mode <= queue_mode_data;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds the store depth");

  a_cursor_in_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |-> (cursor < count))
    else $error("dump cursor ran past the stored entries");

  a_push_grows : assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.op == OP_PUSH && count != CW'(DEPTH))
    |=> (count == $past(count) + CW'(1)))
    else $error("successful push did not grow the store");

  a_store_stable_in_send : assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |=> $stable(front) && $stable(count))
    else $error("store pointers moved while results were being sent");

endmodule

`default_nettype wire

// File: sv/stack_queue_engine.sv
// Top level of the stack/queue engine: a command queue front end feeding a
// ring-store back end. Depends on sqe_pkg, sqe_front and sqe_back.
//
// Usage: each input transaction carries an op on s_axis_tuser and a signed
// 32-bit value on s_axis_tdata. Push places the value at the front (stack
// mode) or at the back (queue mode, set through queue_mode_we/queue_mode_data
// while the block is idle). Pop drops the front, swap exchanges the two front
// entries, peek returns the front and dump returns every entry front first.
// Results leave on the m_axis group: tdata is the entry, tuser holds
// data_valid in bit 0 and the status code above it, tlast marks the final
// result of one input. Successful push, pop and swap, an empty dump and the
// unused op codes produce no result.
// Timing: the front end takes one transaction per cycle until its two-entry
// command queue fills. The back end completes push, pop and failed ops in
// S_IDLE, a swap via S_SWAP_B, S_SWAP_WA and S_SWAP_WB (one write port) and a
// peek or dump in S_SEND, reading the store ahead of each result; a dump's
// later results follow one per cycle while the receiver holds tready high.
// Reset (rst, synchronous) empties the store and the command queue and sets
// stack mode; entry contents are not cleared. When the receiver holds tready
// low, the output register keeps its result, the back end waits and the
// command queue absorbs up to two more transactions before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module stack_queue_engine #(
  parameter int DEPTH = sqe_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          queue_mode_we,
  input  wire logic                          queue_mode_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [sqe_pkg::DATA_W-1:0]    s_axis_tdata,   // value
  input  wire logic [sqe_pkg::OP_W-1:0]      s_axis_tuser,   // op
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [sqe_pkg::DATA_W-1:0]         m_axis_tdata,   // data
  output logic [sqe_pkg::STATUS_W:0]         m_axis_tuser,   // data_valid, status
  output logic                               m_axis_tlast    // last
);
  import sqe_pkg::*;

  // Command handoff between the front end and the back end.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  sqe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  // The back end owns the store, its pointers, the mode register and the
  // output register.
  sqe_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_mode_we  (queue_mode_we),
    .queue_mode_data(queue_mode_data),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: sim/stack_queue_engine_tb.sv
// Self-checking testbench for stack_queue_engine: directed corner cases, then
// random op sequences checked against a shadow copy of the ring store.
// Depends on sqe_pkg and the stack_queue_engine RTL.
`timescale 1ns / 1ps

module stack_queue_engine_tb;

  import sqe_pkg::*;

  // The shadow ring is indexed with a 6-bit front pointer, so the depth must
  // match the block's default depth of 64.
  localparam int SHADOW_DEPTH  = DEPTH_DEF;
  // Cycles the sender waits, after the last expected result, before it
  // touches the mode register. Covers the command queue plus a swap.
  localparam int SETTLE_CYCLES = 16;
  // Cycles allowed to pass at the end once nothing is outstanding.
  localparam int TAIL_CYCLES   = 20;
  // Watchdog: cycles in a row with no transaction on either side.
  localparam int STALL_LIMIT   = 1000;
  localparam int ITEM_TARGET   = 380;
  localparam int PHASES        = 8;

  localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_ZERO = 32'h0000_0000;
  localparam logic [DATA_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

  // What the sender has queued up: a command, a mode register write that
  // waits for the block to go idle first, or a plain wait for idle.
  typedef enum logic [1:0] {
    ENTRY_CMD,
    ENTRY_CFG,
    ENTRY_SYNC
  } entry_kind_t;

  typedef struct {
    entry_kind_t       kind;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    logic              mode;
    int                idle_pct;
  } backlog_entry_t;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic                last;
  } engine_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                queue_mode_we   = 1'b0;
  logic                queue_mode_data = 1'b0;
  logic                s_axis_tvalid   = 1'b0;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata    = '0;
  logic [OP_W-1:0]     s_axis_tuser    = OP_PEEK;
  logic                m_axis_tvalid;
  logic                m_axis_tready   = 1'b1;
  logic [DATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W:0]   m_axis_tuser;
  logic                m_axis_tlast;

  // Stimulus still to be sent, and results the shadow store says are due.
  backlog_entry_t cmd_backlog[$];
  engine_result_t due_results[$];

  // Shadow copy of the engine state. Entries never written are never read,
  // since every slot inside the count was filled by a push.
  logic [DATA_W-1:0] shadow_ring [SHADOW_DEPTH];
  logic [5:0]        shadow_front      = '0;
  logic [6:0]        shadow_count      = '0;
  logic              shadow_queue_mode = 1'b0;

  // Handshake bookkeeping shared between the driver, receiver and monitor.
  logic in_fire       = 1'b0;
  int   gap_left      = 0;
  int   settle_cycles = 0;
  int   idle_pct_now  = 0;
  int   stall_left    = 0;
  int   quiet_cycles  = 0;
  int   errors        = 0;

  // Stimulus generation state: the count of entries the store will hold
  // after the queued commands, the number of real commands queued, and the
  // idle rate stamped on each new entry.
  int gen_count      = 0;
  int gen_total      = 0;
  int phase_idle_pct = 0;

  always #5 clk = ~clk;

  stack_queue_engine dut (
    .clk             (clk),
    .rst             (rst),
    .queue_mode_we   (queue_mode_we),
    .queue_mode_data (queue_mode_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),   // value
    .s_axis_tuser    (s_axis_tuser),   // op
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),   // data
    .m_axis_tuser    (m_axis_tuser),   // data_valid, status
    .m_axis_tlast    (m_axis_tlast)    // last
  );

  // ---------------------------------------------------------------------
  // Shadow store
  // ---------------------------------------------------------------------

  task automatic expect_result(input logic [DATA_W-1:0] data, input logic valid,
                               input logic [STATUS_W-1:0] status, input logic last);
    due_results.push_back('{data: data, valid: valid, status: status, last: last});
  endtask

  // Applies one accepted command to the shadow store and queues every result
  // it should produce. Failed ops leave the store untouched and give a single
  // status result; ops five to seven do nothing at all.
  task automatic shadow_execute(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
    logic [5:0]        a;
    logic [5:0]        b;
    logic [DATA_W-1:0] t;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= SHADOW_DEPTH) begin
          expect_result(VAL_ZERO, 1'b0, ST_PUSH_FULL, 1'b1);
        end else begin
          if (shadow_queue_mode) begin
            a = shadow_front + shadow_count[5:0];
            shadow_ring[a] = value;
          end else begin
            // Stack mode grows the ring backwards from the front.
            shadow_front = shadow_front - 6'd1;
            shadow_ring[shadow_front] = value;
          end
          shadow_count = shadow_count + 7'd1;
        end
      end
      OP_DUMP: begin
        // An empty store dumps nothing at all.
        for (int i = 0; i < shadow_count; i++) begin
          a = shadow_front + 6'(i);
          expect_result(shadow_ring[a], 1'b1, ST_OK, i == shadow_count - 1);
        end
      end
      OP_PEEK: begin
        if (shadow_count == 0) begin
          expect_result(VAL_ZERO, 1'b0, ST_PEEK_EMPTY, 1'b1);
        end else begin
          expect_result(shadow_ring[shadow_front], 1'b1, ST_OK, 1'b1);
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          expect_result(VAL_ZERO, 1'b0, ST_POP_EMPTY, 1'b1);
        end else begin
          shadow_front = shadow_front + 6'd1;
          shadow_count = shadow_count - 7'd1;
        end
      end
      OP_SWAP: begin
        if (shadow_count < 2) begin
          expect_result(VAL_ZERO, 1'b0, ST_SWAP_SHORT, 1'b1);
        end else begin
          a = shadow_front;
          b = shadow_front + 6'd1;
          t = shadow_ring[a];
          shadow_ring[a] = shadow_ring[b];
          shadow_ring[b] = t;
        end
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------

  task automatic add_cmd(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
    cmd_backlog.push_back('{kind: ENTRY_CMD, op: op, value: value, mode: 1'b0,
                            idle_pct: phase_idle_pct});
    if (op <= OP_SWAP) gen_total++;
    if (op == OP_PUSH && gen_count < SHADOW_DEPTH) gen_count++;
    if (op == OP_POP && gen_count > 0) gen_count--;
  endtask

  task automatic add_cfg(input logic mode);
    cmd_backlog.push_back('{kind: ENTRY_CFG, op: OP_PEEK, value: VAL_ZERO, mode: mode,
                            idle_pct: phase_idle_pct});
  endtask

  task automatic add_sync();
    cmd_backlog.push_back('{kind: ENTRY_SYNC, op: OP_PEEK, value: VAL_ZERO, mode: 1'b0,
                            idle_pct: phase_idle_pct});
  endtask

  // Mostly random 32-bit values, with the signed extremes, zero and all ones
  // showing up often enough to matter.
  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_ZERO;
      3:       return VAL_ONES;
      default: return $urandom();
    endcase
  endfunction

  // push_pct steers whether the store tends to fill up or to drain.
  function automatic logic [OP_W-1:0] random_op(input int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return OP_PUSH;
    r = $urandom_range(99);
    if (r < 40) return OP_POP;
    if (r < 58) return OP_PEEK;
    if (r < 76) return OP_SWAP;
    if (r < 92) return OP_DUMP;
    return OP_W'($urandom_range(OP_SWAP + 1, (1 << OP_W) - 1));
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents one command transaction at a time, changing inputs on
  // the falling edge. Mode writes and syncs only go out once the block has
  // delivered everything due and sat quiet for SETTLE_CYCLES.
  // ---------------------------------------------------------------------

  always @(negedge clk) begin : feed_commands
    backlog_entry_t    head;
    logic              nv;
    logic              nwe;
    logic              nwd;
    logic [OP_W-1:0]   nop;
    logic [DATA_W-1:0] nval;
    nv   = s_axis_tvalid;
    nop  = s_axis_tuser;
    nval = s_axis_tdata;
    nwe  = 1'b0;
    nwd  = queue_mode_data;
    if (rst) begin
      nv = 1'b0;
    end else begin
      // The transaction on the bus went through at the last rising edge.
      if (nv && in_fire) nv = 1'b0;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          head = cmd_backlog[0];
          if (head.kind == ENTRY_CMD) begin
            nv           = 1'b1;
            nop          = head.op;
            nval         = head.value;
            idle_pct_now = head.idle_pct;
            void'(cmd_backlog.pop_front());
            if ($urandom_range(99) < idle_pct_now) gap_left = $urandom_range(1, 6);
          end else if (due_results.size() != 0) begin
            settle_cycles = 0;
          end else if (settle_cycles < SETTLE_CYCLES) begin
            settle_cycles++;
          end else begin
            // The block is idle: the mode change cannot hit a command in flight,
            // so the shadow mode is switched at the same moment.
            settle_cycles = 0;
            idle_pct_now  = head.idle_pct;
            if (head.kind == ENTRY_CFG) begin
              nwe               = 1'b1;
              nwd               = head.mode;
              shadow_queue_mode = head.mode;
            end
            void'(cmd_backlog.pop_front());
          end
        end
      end
    end
    s_axis_tvalid   <= nv;
    s_axis_tuser    <= nop;
    s_axis_tdata    <= nval;
    queue_mode_we   <= nwe;
    queue_mode_data <= nwd;
  end

  // Receiver: holds tready low in bursts of random length at the current
  // idle rate, and keeps it high when the rate is zero.
  always @(negedge clk) begin : accept_results
    logic nready;
    if (stall_left > 0) begin
      stall_left--;
      nready = 1'b0;
    end else if ($urandom_range(99) < idle_pct_now) begin
      stall_left = $urandom_range(0, 5);
      nready     = 1'b0;
    end else begin
      nready = 1'b1;
    end
    m_axis_tready <= nready;
  end

  // ---------------------------------------------------------------------
  // Monitor: on each rising edge, an accepted command updates the shadow
  // store, and an accepted result is checked against the oldest one due.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : watch_ports
    engine_result_t want;
    engine_result_t got;
    if (rst) begin
      in_fire      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) shadow_execute(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{data: m_axis_tdata, valid: m_axis_tuser[0],
                status: m_axis_tuser[STATUS_W:1], last: m_axis_tlast};
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: data=%h valid=%b status=%0d last=%b",
                   $time, got.data, got.valid, got.status, got.last);
        end else begin
          want = due_results.pop_front();
          if (got.data !== want.data) begin
            errors++;
            $display("%0t: data mismatch: expected %h, actual %h", $time, want.data, got.data);
          end
          if (got.valid !== want.valid) begin
            errors++;
            $display("%0t: data_valid mismatch: expected %b, actual %b",
                     $time, want.valid, got.valid);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, got.last);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog: a hang on either side stops the run.
  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin : run_test
    int push_pct;
    int budget;

    // Directed part, in stack mode with no idling. The mode register is
    // written once right after reset so that a write of zero is covered too.
    phase_idle_pct = 0;
    add_cfg(1'b0);
    // Every failing op on an empty store, an empty dump, and the unused codes.
    add_cmd(OP_PEEK, VAL_ONES);
    add_cmd(OP_POP, VAL_MAX);
    add_cmd(OP_SWAP, VAL_MIN);
    add_cmd(OP_DUMP, VAL_ONES);
    for (int u = OP_SWAP + 1; u < (1 << OP_W); u++) add_cmd(OP_W'(u), random_value());
    // A swap with one entry is still too short.
    add_cmd(OP_PUSH, VAL_MIN);
    add_cmd(OP_SWAP, VAL_ZERO);
    add_cmd(OP_PUSH, VAL_MAX);
    add_cmd(OP_PUSH, VAL_ZERO);
    add_cmd(OP_PUSH, VAL_ONES);
    add_cmd(OP_SWAP, VAL_ZERO);
    add_cmd(OP_PEEK, VAL_ZERO);
    add_cmd(OP_DUMP, VAL_ZERO);
    add_cmd(OP_POP, VAL_ZERO);
    add_cmd(OP_PEEK, VAL_ZERO);
    // Switching to queue mode while holding entries keeps their order; new
    // pushes then land at the back.
    add_cfg(1'b1);
    add_cmd(OP_PUSH, 32'h5A5A_A5A5);
    add_cmd(OP_PUSH, 32'h0000_0001);
    add_cmd(OP_DUMP, VAL_ZERO);
    while (gen_count > 0) add_cmd(OP_POP, random_value());
    add_cmd(OP_POP, VAL_ZERO);

    // Random part, in phases. Each phase starts with a mode write once the
    // block is idle; the idle rate changes per phase, with one phase and the
    // final phase running flat out.
    budget = (ITEM_TARGET - gen_total) / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      phase_idle_pct = (p == 2 || p == PHASES - 1) ? 0 : $urandom_range(15, 45);
      push_pct       = (p % 2 == 0) ? 55 : 30;
      if (p == 0) begin
        add_cfg(1'b1);
      end else if (p == 1) begin
        add_cfg(1'b0);
      end else begin
        add_cfg(1'($urandom_range(1)));
      end
      if (p == 3) begin
        // Fill the store to the brim, hit the full case, dump all 64 entries,
        // then drain it completely with a few swaps mixed in.
        while (gen_count < SHADOW_DEPTH) add_cmd(OP_PUSH, random_value());
        add_cmd(OP_PUSH, random_value());
        add_cmd(OP_PEEK, random_value());
        add_cmd(OP_SWAP, random_value());
        add_cmd(OP_PUSH, random_value());
        add_cmd(OP_DUMP, random_value());
        while (gen_count > 0) begin
          if ($urandom_range(7) == 0) add_cmd(OP_SWAP, random_value());
          add_cmd(OP_POP, random_value());
        end
        add_cmd(OP_SWAP, random_value());
      end
      while (gen_total < ITEM_TARGET - (PHASES - 1 - p) * budget) begin
        add_cmd(random_op(push_pct), random_value());
        // Halfway through one phase the sender holds off until every result
        // due so far has come back.
        if (p == 5 && gen_total == ITEM_TARGET - (PHASES - p) * budget + budget / 2) begin
          add_sync();
        end
      end
    end

    // Reset is released on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every command transaction has gone out and every expected
    // result has come back, then give the block time to show strays.
    do begin
      @(posedge clk);
      #1;
    end while (cmd_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    #1;

    if (errors == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: stack_queue_engine.f
sv/sqe_pkg.sv
sv/sqe_front.sv
sv/sqe_back.sv
sv/stack_queue_engine.sv
sim/stack_queue_engine_tb.sv
